// ===== rtl/core/gbc_pkg.sv =====
// Shared types and constants for the two-coloring check block.
package gbc_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned CountW   = 9;
  localparam int unsigned NodeW    = 8;
  localparam int unsigned MinNodes = 2;

  typedef enum logic [OpW-1:0] {
    OP_START  = 2'd0,
    OP_EDGE   = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_E_RDA,
    ST_E_WRA,
    ST_E_WRB,
    ST_F_INIT,
    ST_F_SEEK,
    ST_F_POP,
    ST_F_POPW,
    ST_F_ROW,
    ST_F_SCAN,
    ST_F_CHK,
    ST_F_DONE
  } state_e;

  typedef struct packed {
    logic take_item;
    logic cnt_clr;
    logic adj_clr_row;
    logic edge_rd_a;
    logic edge_wr_a;
    logic edge_wr_b;
    logic vis_clr;
    logic seed;
    logic s_inc;
    logic pop;
    logic row_rd;
    logic row_load;
    logic w_visit;
    logic w_chk_rd;
    logic w_inc;
    logic set_fail;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic edge_ok;
    logic n_small;
    logic s_end;
    logic s_vis;
    logic q_empty;
    logic w_end;
    logic w_bit;
    logic w_vis;
    logic color_eq;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/gbc_if.sv =====
// Valid/ready channel interfaces for graph items and verdicts.
interface gbc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [8:0] node_count;
  logic [7:0] node_a;
  logic [7:0] node_b;
  modport source (output valid, op, node_count, node_a, node_b, input ready);
  modport sink (input valid, op, node_count, node_a, node_b, output ready);
endinterface

interface gbc_out_if;
  logic valid;
  logic ready;
  logic bicolorable;
  modport source (output valid, bicolorable, input ready);
  modport sink (input valid, bicolorable, output ready);
endinterface

// ===== rtl/core/gbc_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module gbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/gbc_ctrl.sv =====
// Sequencer for graph load, adjacency clear and breadth-first coloring.
module gbc_ctrl import gbc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (status_i.op)
            OP_START: begin
              cmd_o.take_item = 1'b1;
              cmd_o.cnt_clr   = 1'b1;
              state_d         = ST_CLR;
            end
            OP_EDGE: begin
              cmd_o.take_item = 1'b1;
              if (status_i.edge_ok) state_d = ST_E_RDA;
            end
            OP_FINISH: state_d = ST_F_INIT;
            default: ;
          endcase
        end
      end
      ST_CLR: begin
        if (status_i.s_end) state_d = ST_IDLE;
        else cmd_o.adj_clr_row = 1'b1;
      end
      ST_E_RDA: begin
        cmd_o.edge_rd_a = 1'b1;
        state_d         = ST_E_WRA;
      end
      ST_E_WRA: begin
        cmd_o.edge_wr_a = 1'b1;
        state_d         = ST_E_WRB;
      end
      ST_E_WRB: begin
        cmd_o.edge_wr_b = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_F_INIT: begin
        cmd_o.vis_clr = 1'b1;
        if (status_i.n_small) begin
          cmd_o.set_fail = 1'b1;
          state_d        = ST_F_DONE;
        end else begin
          state_d = ST_F_SEEK;
        end
      end
      ST_F_SEEK: begin
        if (status_i.s_end) begin
          state_d = ST_F_DONE;
        end else if (status_i.s_vis) begin
          cmd_o.s_inc = 1'b1;
        end else begin
          cmd_o.seed = 1'b1;
          state_d    = ST_F_POP;
        end
      end
      ST_F_POP: begin
        if (status_i.q_empty) begin
          cmd_o.s_inc = 1'b1;
          state_d     = ST_F_SEEK;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = ST_F_POPW;
        end
      end
      ST_F_POPW: begin
        cmd_o.row_rd = 1'b1;
        state_d      = ST_F_ROW;
      end
      ST_F_ROW: begin
        cmd_o.row_load = 1'b1;
        state_d        = ST_F_SCAN;
      end
      ST_F_SCAN: begin
        if (status_i.w_end) begin
          state_d = ST_F_POP;
        end else if (!status_i.w_bit) begin
          cmd_o.w_inc = 1'b1;
        end else if (!status_i.w_vis) begin
          cmd_o.w_visit = 1'b1;
        end else begin
          cmd_o.w_chk_rd = 1'b1;
          state_d        = ST_F_CHK;
        end
      end
      ST_F_CHK: begin
        if (status_i.color_eq) begin
          cmd_o.set_fail = 1'b1;
          state_d        = ST_F_DONE;
        end else begin
          cmd_o.w_inc = 1'b1;
          state_d     = ST_F_SCAN;
        end
      end
      ST_F_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/gbc_dpath.sv =====
// Datapath: adjacency, color and queue memories, counters, visited bits, result register.
module gbc_dpath import gbc_pkg::*; #(
  parameter int unsigned MAX_NODES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [OpW-1:0]    op_i,
  input  logic [CountW-1:0] node_count_i,
  input  logic [NodeW-1:0]  node_a_i,
  input  logic [NodeW-1:0]  node_b_i,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              bicolorable_o
);

  localparam int unsigned NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);

  logic [CW-1:0]        n_q, s_q, w_q, head_q, tail_q;
  logic [NW-1:0]        a_q, b_q;
  logic [MAX_NODES-1:0] vis_q, row_q;
  logic                 cv_q, ok_q, out_valid_q, out_bit_q;

  logic                 adj_we, adj_re, col_we, col_re, q_we, q_re;
  logic [NW-1:0]        adj_waddr, adj_raddr, col_waddr, col_raddr, q_waddr;
  logic [MAX_NODES-1:0] adj_wdata, adj_rdata;
  logic                 col_wdata, col_rdata;
  logic [NW-1:0]        q_wdata, q_rdata;
  logic [NW-1:0]        s_idx, w_idx;

  assign s_idx = s_q[NW-1:0];
  assign w_idx = w_q[NW-1:0];

  // Memory port steering
  always_comb begin
    adj_we    = cmd_i.adj_clr_row | cmd_i.edge_wr_a | cmd_i.edge_wr_b;
    adj_waddr = s_idx;
    adj_wdata = '0;
    if (cmd_i.edge_wr_a) begin
      adj_waddr = a_q;
      adj_wdata = adj_rdata | (MAX_NODES'(1) << b_q);
    end else if (cmd_i.edge_wr_b) begin
      adj_waddr = b_q;
      adj_wdata = adj_rdata | (MAX_NODES'(1) << a_q);
    end
    adj_re    = cmd_i.edge_rd_a | cmd_i.edge_wr_a | cmd_i.row_rd;
    adj_raddr = cmd_i.row_rd ? q_rdata : (cmd_i.edge_wr_a ? b_q : a_q);

    col_we    = cmd_i.seed | cmd_i.w_visit;
    col_waddr = cmd_i.seed ? s_idx : w_idx;
    col_wdata = cmd_i.seed ? 1'b0 : ~cv_q;
    col_re    = cmd_i.row_rd | cmd_i.w_chk_rd;
    col_raddr = cmd_i.row_rd ? q_rdata : w_idx;

    q_we      = cmd_i.seed | cmd_i.w_visit;
    q_waddr   = cmd_i.seed ? '0 : tail_q[NW-1:0];
    q_wdata   = cmd_i.seed ? s_idx : w_idx;
    q_re      = cmd_i.pop;
  end

  gbc_ram #(.Width(MAX_NODES), .Depth(MAX_NODES)) u_adj_ram (
    .clk_i, .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .re_i(adj_re), .raddr_i(adj_raddr), .rdata_o(adj_rdata)
  );

  gbc_ram #(.Width(1), .Depth(MAX_NODES)) u_color_ram (
    .clk_i, .we_i(col_we), .waddr_i(col_waddr), .wdata_i(col_wdata),
    .re_i(col_re), .raddr_i(col_raddr), .rdata_o(col_rdata)
  );

  gbc_ram #(.Width(NW), .Depth(MAX_NODES)) u_queue_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .re_i(q_re), .raddr_i(head_q[NW-1:0]), .rdata_o(q_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      s_q         <= '0;
      w_q         <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      vis_q       <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take_item && (op_e'(op_i) == OP_START)) begin
        n_q <= (int'(node_count_i) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count_i);
      end
      if (cmd_i.cnt_clr || cmd_i.vis_clr) s_q <= '0;
      else if (cmd_i.adj_clr_row || cmd_i.s_inc) s_q <= s_q + 1'b1;
      if (cmd_i.vis_clr) begin
        vis_q <= '0;
        ok_q  <= 1'b1;
      end
      if (cmd_i.seed) begin
        vis_q[s_idx] <= 1'b1;
        head_q       <= '0;
        tail_q       <= CW'(1);
      end
      if (cmd_i.pop) head_q <= head_q + 1'b1;
      if (cmd_i.row_load) w_q <= '0;
      else if (cmd_i.w_inc || cmd_i.w_visit) w_q <= w_q + 1'b1;
      if (cmd_i.w_visit) begin
        vis_q[w_idx] <= 1'b1;
        tail_q       <= tail_q + 1'b1;
      end
      if (cmd_i.set_fail) ok_q <= 1'b0;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      a_q <= NW'(node_a_i);
      b_q <= NW'(node_b_i);
    end
    if (cmd_i.row_load) begin
      row_q <= adj_rdata;
      cv_q  <= col_rdata;
    end
    if (cmd_i.out_load) out_bit_q <= ok_q & ~cmd_i.set_fail;
  end

  always_comb begin
    status_o.op       = op_e'(op_i);
    status_o.edge_ok  = (int'(node_a_i) < int'(n_q)) && (int'(node_b_i) < int'(n_q));
    status_o.n_small  = int'(n_q) < MinNodes;
    status_o.s_end    = s_q == n_q;
    status_o.s_vis    = vis_q[s_idx];
    status_o.q_empty  = head_q == tail_q;
    status_o.w_end    = w_q == n_q;
    status_o.w_bit    = row_q[w_idx];
    status_o.w_vis    = vis_q[w_idx];
    status_o.color_eq = col_rdata == cv_q;
    status_o.out_free = ~out_valid_q | out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign bicolorable_o = out_bit_q;

endmodule

// ===== rtl/core/graph_bipartite_check_unit.sv =====
// Top level of the graph two-coloring (bipartiteness) check block.
//
//  channel | dir | payload                              | transfer when
//  in_i    | in  | op, node_count, node_a, node_b       | in_i.valid & in_i.ready
//  out_o   | out | bicolorable                          | out_o.valid & out_o.ready
//
// Start takes the count, then clears one adjacency row per cycle until all n rows are clear;
// an edge with an endpoint out of range is dropped, else both rows get a read-modify-write.
// Finish walks the graph breadth first with a single-bit scan over each adjacency row, and
// reads and compares the color of every neighbour that is already visited.
// Reset clears the sequencer, node count and visited bits; memories are not swept.
// The verdict sits in an output register; new items are taken while it waits.
module graph_bipartite_check_unit import gbc_pkg::*; #(
  parameter int unsigned MAX_NODES = 256
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  gbc_in_if.sink     in_i,
  gbc_out_if.source  out_o
);

  cmd_t    cmd;
  status_t status;

  gbc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gbc_dpath #(.MAX_NODES(MAX_NODES)) u_dpath (
    .clk_i,
    .rst_ni,
    .op_i          (in_i.op),
    .node_count_i  (in_i.node_count),
    .node_a_i      (in_i.node_a),
    .node_b_i      (in_i.node_b),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .bicolorable_o (out_o.bicolorable)
  );

endmodule

// ===== rtl/core/gbc_checker.sv =====
// Port-level checks for the two-coloring block, bound to the top level.
module gbc_checker import gbc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_op_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_bit_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_bit_i))
    else $error("verdict dropped or changed while stalled");

  a_no_result_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_op_i != OP_FINISH) |=> !$rose(out_valid_i))
    else $error("result raised right after a non-finish transfer");

  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_op_i == OP_FINISH) |=> !in_ready_i)
    else $error("input taken during coloring");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("verdict appeared without a coloring pass");

endmodule

bind graph_bipartite_check_unit gbc_checker u_gbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.op),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_bit_i   (out_o.bicolorable)
);

// ===== tb/graph_bipartite_check_unit_tb.sv =====
// Testbench for the graph two-coloring check block: directed table, then random graphs.
`timescale 1ns / 100ps

module graph_bipartite_check_unit_tb;
  import gbc_pkg::*;

  localparam int unsigned NODES      = 256;
  localparam int unsigned ITEM_GOAL  = 1500;
  localparam int unsigned HOLD_LEN   = 2500;
  localparam longint      CYCLE_CAP  = 2_000_000;
  localparam int          PREDICTED  = -1;

  typedef struct {
    op_e        op;
    logic [8:0] cnt;
    logic [7:0] a;
    logic [7:0] b;
    int         verdict;  // PREDICTED, or the verdict typed in
  } graph_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  gbc_in_if  in_if ();
  gbc_out_if out_if ();

  graph_bipartite_check_unit #(.MAX_NODES(NODES)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the graph, kept at the block's widths
  logic [NODES-1:0] shadow_adj [NODES];
  logic [8:0]       shadow_n;

  bit     verdicts_due [$];
  int     errors;
  int     items_sent;
  int     graphs_started;
  int     verdicts_one;
  int     verdicts_zero;
  longint cycles;
  bit     calm;      // no idling on either side while set
  bit     hold_req;  // driver asks the receiver for one long hold-off

  // Breadth-first two-coloring over every component of the shadow graph; under two nodes fails.
  function automatic bit graph_two_colorable();
    bit        seen [NODES];
    bit        color [NODES];
    int        fifo [$];
    int        v;
    for (int i = 0; i < NODES; i++) seen[i] = 1'b0;
    if (shadow_n < 2) return 1'b0;
    for (int s = 0; s < shadow_n; s++) begin
      if (seen[s]) continue;
      seen[s]  = 1'b1;
      color[s] = 1'b0;
      fifo.insert(fifo.size(), s);
      while (fifo.size() != 0) begin
        v = fifo.pop_front();
        for (int w = 0; w < shadow_n; w++) begin
          if (!shadow_adj[v][w]) continue;
          if (!seen[w]) begin
            seen[w]  = 1'b1;
            color[w] = ~color[v];
            fifo.insert(fifo.size(), w);
          end else if (color[w] == color[v]) begin
            return 1'b0;
          end
        end
      end
    end
    return 1'b1;
  endfunction

  // Update the shadow graph on an accepted transfer; queue the verdict on finish.
  function automatic void graph_apply(graph_item_t it);
    bit got;
    case (it.op)
      OP_START: begin
        shadow_n = (it.cnt > NODES) ? 9'(NODES) : it.cnt;
        for (int i = 0; i < NODES; i++) shadow_adj[i] = '0;
        graphs_started++;
      end
      OP_EDGE: begin
        if (it.a < shadow_n && it.b < shadow_n) begin
          shadow_adj[it.a][it.b] = 1'b1;
          shadow_adj[it.b][it.a] = 1'b1;
        end
      end
      OP_FINISH: begin
        got = graph_two_colorable();
        verdicts_due.insert(verdicts_due.size(),
                            (it.verdict == PREDICTED) ? got : it.verdict[0]);
      end
      default: ;  // unused op: no effect
    endcase
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_item(graph_item_t it);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.op         <= it.op;
    in_if.node_count <= it.cnt;
    in_if.node_a     <= it.a;
    in_if.node_b     <= it.b;
    do @(posedge clk_i); while (!in_if.ready);
    graph_apply(it);
    items_sent++;
  endtask

  function automatic graph_item_t mk(op_e op, int cnt, int a, int b, int verdict);
    graph_item_t it;
    it.op      = op;
    it.cnt     = 9'(cnt);
    it.a       = 8'(a);
    it.b       = 8'(b);
    it.verdict = verdict;
    return it;
  endfunction

  // One random graph: start, edges (mostly across a random split), noise, finish.
  task automatic send_random_graph();
    int  n;
    int  edges;
    int  a;
    int  b;
    bit  side [NODES];
    bit  split;
    int  r;
    r = $urandom_range(99);
    if (r < 4) n = $urandom_range(1, 0);
    else if (r < 97) n = $urandom_range(12, 2);
    else n = $urandom_range(511, 0);  // rare wide count, exercises every count bit
    split = ($urandom_range(99) < 65);
    for (int i = 0; i < NODES; i++) side[i] = $urandom_range(1);
    send_item(mk(OP_START, n, $urandom_range(255), $urandom_range(255), PREDICTED));
    edges = $urandom_range(2 * n + 2);
    if (edges > 40) edges = 40;
    for (int e = 0; e < edges; e++) begin
      r = $urandom_range(99);
      a = $urandom_range((n > 1) ? ((n > NODES) ? NODES - 1 : n - 1) : 0);
      b = $urandom_range((n > 1) ? ((n > NODES) ? NODES - 1 : n - 1) : 0);
      if (r < 8) begin
        a = $urandom_range(255);  // likely out of range
        b = $urandom_range(255);
      end else if (r < 10) begin
        send_item(mk(OP_NONE, $urandom_range(511), a, b, PREDICTED));
        continue;
      end else if (split && side[a] == side[b] && r < 97) begin
        continue;  // keep the split graph two-colorable
      end
      send_item(mk(OP_EDGE, $urandom_range(511), a, b, PREDICTED));
    end
    send_item(mk(OP_FINISH, $urandom_range(511), $urandom_range(255),
                 $urandom_range(255), PREDICTED));
    if ($urandom_range(9) == 0)
      send_item(mk(OP_FINISH, 0, 0, 0, PREDICTED));  // repeated finish keeps graph
  endtask

  // Receiver: checks each verdict transfer, then picks ready for the next cycle.
  initial begin : verdict_sink
    int stall_left;
    int hold_left;
    bit want;
    stall_left   = 0;
    hold_left    = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict transfer with none expected: bicolorable=%0b", out_if.bicolorable);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_if.bicolorable !== want) begin
            $error("bicolorable: expected %0b, got %0b", want, out_if.bicolorable);
            errors++;
          end
          if (want) verdicts_one++; else verdicts_zero++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        hold_left    = HOLD_LEN;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(3) == 0) begin
        stall_left   = ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("graph_bipartite_check_unit_tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    graph_item_t plan [$];
    bit          held;
    errors         = 0;
    items_sent     = 0;
    graphs_started = 0;
    verdicts_one   = 0;
    verdicts_zero  = 0;
    cycles         = 0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    held           = 1'b0;
    shadow_n       = '0;
    for (int i = 0; i < NODES; i++) shadow_adj[i] = '0;
    in_if.valid      <= 1'b0;
    in_if.op         <= OP_NONE;
    in_if.node_count <= '0;
    in_if.node_a     <= '0;
    in_if.node_b     <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    plan.insert(plan.size(), mk(OP_FINISH, 0, 0, 0, 0));            // finish before any start
    plan.insert(plan.size(), mk(OP_NONE, 511, 255, 255, PREDICTED)); // unused op ignored
    plan.insert(plan.size(), mk(OP_START, 300, 0, 0, PREDICTED));   // count saturates
    plan.insert(plan.size(), mk(OP_EDGE, 0, 255, 0, PREDICTED));
    plan.insert(plan.size(), mk(OP_EDGE, 0, 254, 255, PREDICTED));
    plan.insert(plan.size(), mk(OP_FINISH, 0, 0, 0, 1));
    plan.insert(plan.size(), mk(OP_START, 0, 0, 0, PREDICTED));     // empty graph
    plan.insert(plan.size(), mk(OP_FINISH, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(OP_START, 1, 0, 0, PREDICTED));     // single node, self loop
    plan.insert(plan.size(), mk(OP_EDGE, 0, 0, 0, PREDICTED));
    plan.insert(plan.size(), mk(OP_FINISH, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(OP_START, 2, 0, 0, PREDICTED));
    plan.insert(plan.size(), mk(OP_EDGE, 0, 0, 1, PREDICTED));
    plan.insert(plan.size(), mk(OP_FINISH, 0, 0, 0, 1));
    plan.insert(plan.size(), mk(OP_FINISH, 0, 0, 0, 1));            // repeated finish
    plan.insert(plan.size(), mk(OP_EDGE, 0, 1, 1, PREDICTED));      // self loop
    plan.insert(plan.size(), mk(OP_FINISH, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(OP_START, 3, 0, 0, PREDICTED));     // odd cycle
    plan.insert(plan.size(), mk(OP_EDGE, 0, 0, 1, PREDICTED));
    plan.insert(plan.size(), mk(OP_EDGE, 0, 1, 2, PREDICTED));
    plan.insert(plan.size(), mk(OP_EDGE, 0, 2, 0, PREDICTED));
    plan.insert(plan.size(), mk(OP_FINISH, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(OP_START, 4, 0, 0, PREDICTED));     // endpoints out of range
    plan.insert(plan.size(), mk(OP_EDGE, 0, 3, 4, PREDICTED));
    plan.insert(plan.size(), mk(OP_EDGE, 0, 255, 0, PREDICTED));
    plan.insert(plan.size(), mk(OP_FINISH, 0, 0, 0, 1));
    foreach (plan[i]) send_item(plan[i]);

    // Random graphs; one stretch with the receiver held off, some with no idling
    while (items_sent < ITEM_GOAL) begin
      if (!held && items_sent > 500) begin
        held     = 1'b1;
        hold_req = 1'b1;
        repeat (6) send_random_graph();
      end
      calm = ($urandom_range(9) == 0);
      send_random_graph();
    end
    calm = 1'b0;
    in_if.valid <= 1'b0;

    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("covered %0d items over %0d graphs; verdicts: %0d bicolorable, %0d not",
             items_sent, graphs_started, verdicts_one, verdicts_zero);
    if (errors == 0) begin
      $display("graph_bipartite_check_unit_tb: clean");
    end else begin
      $display("graph_bipartite_check_unit_tb: errors");
    end
    $finish;
  end

endmodule
